// ===== design/fqm_pkg.sv =====
// fqm_pkg: shared types, constants and tables for the two-component Faraday Q/U unit.
// Used by every module in the design folder; depends on nothing.
package fqm_pkg;

  // port and field widths
  localparam int LAM_W      = 32;
  localparam int OUT_W      = 18;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 29;

  // CORDIC sizing
  localparam int CORDIC_STAGES_DEF = 18;
  localparam int CORDIC_MAX        = 24;
  localparam int XW                = 34;  // x/y datapath, signed
  localparam int ZW                = 33;  // residual angle, signed turn fraction

  // damping series
  localparam int HORNER_TERMS = 12;
  localparam int EXP_STAGES   = 31;       // largest integer part of 2*t^2

  // fixed-point constants
  localparam logic [30:0] INV_PI   = 31'd1367130551;  // round(2^32/pi)
  localparam logic [31:0] GAIN_Q32 = 32'd2608131496;  // CORDIC gain inverse, Q.32
  localparam logic [30:0] E_INV    = 31'd1580030169;  // e^-1, Q.32
  localparam logic [32:0] ONE_Q32  = 33'h1_0000_0000;

  // arctan(2^-i) as a 32-bit turn fraction
  localparam logic [31:0] ATAN_TURNS [CORDIC_MAX] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  // floor(2^36/k) for the Horner divisors k = 12 down to 1
  localparam logic [36:0] HORNER_RECIP [HORNER_TERMS] = '{
    37'(64'h10_0000_0000 / 64'd12), 37'(64'h10_0000_0000 / 64'd11),
    37'(64'h10_0000_0000 / 64'd10), 37'(64'h10_0000_0000 / 64'd9),
    37'(64'h10_0000_0000 / 64'd8),  37'(64'h10_0000_0000 / 64'd7),
    37'(64'h10_0000_0000 / 64'd6),  37'(64'h10_0000_0000 / 64'd5),
    37'(64'h10_0000_0000 / 64'd4),  37'(64'h10_0000_0000 / 64'd3),
    37'(64'h10_0000_0000 / 64'd2),  37'(64'h10_0000_0000 / 64'd1)
  };

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AMP_ONE, REG_AMP_TWO, REG_ANGLE_ONE, REG_ANGLE_TWO,
    REG_RM_ONE, REG_RM_TWO, REG_DISPERSION
  } cfg_reg_t;

  // quadrant of the phase
  typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quad_t;

  typedef struct packed {
    logic [16:0] amp_one;
    logic [16:0] amp_two;
    logic [15:0] angle_one;
    logic [15:0] angle_two;
    logic [28:0] rot_measure_one;
    logic [28:0] rot_measure_two;
    logic [23:0] dispersion;
  } cfg_t;

  // one component, ready for the rotator
  typedef struct packed {
    quad_t       quad;
    logic [31:0] resid;   // signed turn fraction within +-1/8 turn
    logic [30:0] x_init;  // amplitude times gain inverse, Q.30
  } comp_t;

  // one classified sample passed from front to back
  typedef struct packed {
    comp_t       comp_one;
    comp_t       comp_two;
    logic [4:0]  exp_int;
    logic [31:0] exp_frac;
    logic        damp_zero;
  } item_t;

endpackage

// ===== design/fqm_front.sv =====
// fqm_front: takes a wavelength sample, forms both component phases and the damping argument.
// Depends on fqm_pkg.
module fqm_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic [31:0]   lam,
  input  fqm_pkg::cfg_t cfg,
  output logic          item_valid,
  output fqm_pkg::item_t item
);
  import fqm_pkg::*;

  // two's complement to magnitude
  function automatic logic [28:0] rm_mag(logic [28:0] rm);
    return rm[28] ? 29'(30'h2000_0000 - {1'b0, rm}) : rm;
  endfunction

  // rotation part, sign, intrinsic angle, then split into quadrant and residual
  function automatic comp_t make_comp(logic [59:0] hi, logic [62:0] lo, logic neg,
                                      logic [15:0] angle, logic [30:0] x0);
    logic [60:0] acc;
    logic [31:0] rot;
    logic [31:0] ph;
    logic [31:0] ph_off;
    logic [31:0] resid;
    logic [1:0]  q;
    comp_t       c;
    acc    = 61'(hi) + 61'(lo[62:32]);
    rot    = acc[43:12];
    if (neg) begin
      rot = 32'(0) - rot;
    end
    ph       = rot + {angle, 16'h0000};
    ph_off   = ph + 32'h2000_0000;
    q        = ph_off[31:30];
    resid    = ph - {q, 30'h0};
    c.quad   = quad_t'(q);
    c.resid  = resid;
    c.x_init = x0;
    return c;
  endfunction

  logic        v1_r, v2_r, item_valid_r;
  logic [60:0] m1_r, m2_r;
  logic        neg1_r, neg2_r, neg1b_r, neg2b_r;
  logic [55:0] s_r;
  logic [30:0] x01_r, x02_r, x01b_r, x02b_r;
  logic [48:0] xp1, xp2;
  logic [62:0] lo1_r, lo2_r;
  logic [59:0] hi1_r, hi2_r;
  logic [51:0] tt_r;
  logic        big_r;
  item_t       item_r;

  assign xp1 = 49'(cfg.amp_one) * 49'(GAIN_Q32);
  assign xp2 = 49'(cfg.amp_two) * 49'(GAIN_Q32);

  // transaction valid through the three front stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      item_valid_r <= 1'b0;
    end else begin
      v1_r         <= accept;
      v2_r         <= v1_r;
      item_valid_r <= v2_r;
    end
  end

  // stage 1: |rm|*L, sigma*L, starting x
  always_ff @(posedge clk) begin
    m1_r   <= 61'(rm_mag(cfg.rot_measure_one)) * 61'(lam);
    m2_r   <= 61'(rm_mag(cfg.rot_measure_two)) * 61'(lam);
    neg1_r <= cfg.rot_measure_one[28];
    neg2_r <= cfg.rot_measure_two[28];
    s_r    <= 56'(cfg.dispersion) * 56'(lam);
    x01_r  <= xp1[48:18];
    x02_r  <= xp2[48:18];
  end

  // stage 2: scale by 1/pi in two halves, square t
  always_ff @(posedge clk) begin
    lo1_r   <= 63'(m1_r[31:0]) * 63'(INV_PI);
    hi1_r   <= 60'(m1_r[60:32]) * 60'(INV_PI);
    lo2_r   <= 63'(m2_r[31:0]) * 63'(INV_PI);
    hi2_r   <= 60'(m2_r[60:32]) * 60'(INV_PI);
    neg1b_r <= neg1_r;
    neg2b_r <= neg2_r;
    x01b_r  <= x01_r;
    x02b_r  <= x02_r;
    tt_r    <= 52'(s_r[45:20]) * 52'(s_r[45:20]);
    big_r   <= |s_r[55:46];  // t reached 4.0
  end

  // stage 3: phases and damping split
  always_ff @(posedge clk) begin
    item_r.comp_one  <= make_comp(hi1_r, lo1_r, neg1b_r, cfg.angle_one, x01b_r);
    item_r.comp_two  <= make_comp(hi2_r, lo2_r, neg2b_r, cfg.angle_two, x02b_r);
    item_r.exp_int   <= tt_r[51:47];
    item_r.exp_frac  <= {tt_r[46:31], 16'h0000};
    item_r.damp_zero <= big_r;
  end

  assign item_valid = item_valid_r;
  assign item       = item_r;

endmodule

// ===== design/fqm_queue.sv =====
// fqm_queue: short FIFO between front and back; the head is popped into a register.
// Depends on fqm_pkg.
module fqm_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  fqm_pkg::item_t push_item,
  output logic           full,
  output logic           pop_valid,
  output fqm_pkg::item_t pop_item
);
  import fqm_pkg::*;

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);

  item_t         mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [PW:0]   cnt_r, cnt_nxt;
  logic          pop;
  logic          pop_valid_r;
  item_t         pop_item_r;

  // back side never stalls, so the head leaves whenever present
  assign pop = (cnt_r != '0);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      cnt_r       <= '0;
      pop_valid_r <= 1'b0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r       <= cnt_nxt;
      pop_valid_r <= pop;
    end
  end

  // storage and registered read
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
    pop_item_r <= mem_r[rd_ptr_r];
  end

  assign full      = (cnt_r == (PW + 1)'(DEPTH));
  assign pop_valid = pop_valid_r;
  assign pop_item  = pop_item_r;

endmodule

// ===== design/fqm_cordic.sv =====
// fqm_cordic: pipelined rotation-mode CORDIC, one stage per iteration, then quadrant fix-up.
// Depends on fqm_pkg.
module fqm_cordic #(
  parameter int STAGES = fqm_pkg::CORDIC_STAGES_DEF
) (
  input  logic                              clk,
  input  fqm_pkg::comp_t                    comp,
  output logic signed [fqm_pkg::XW-1:0]     x_out,
  output logic signed [fqm_pkg::XW-1:0]     y_out
);
  import fqm_pkg::*;

  logic signed [XW-1:0] x_r [STAGES+1];
  logic signed [XW-1:0] y_r [STAGES+1];
  logic signed [ZW-1:0] z_r [STAGES+1];
  quad_t                qd_r [STAGES+1];
  logic signed [XW-1:0] x_out_r, y_out_r;

  // load, micro-rotations, quadrant rotation
  always_ff @(posedge clk) begin
    x_r[0]  <= {{(XW-31){1'b0}}, comp.x_init};
    y_r[0]  <= '0;
    z_r[0]  <= {{(ZW-32){comp.resid[31]}}, comp.resid};
    qd_r[0] <= comp.quad;
    for (int i = 0; i < STAGES; i++) begin
      if (!z_r[i][ZW-1]) begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] - signed'(ZW'(ATAN_TURNS[i]));
      end else begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] + signed'(ZW'(ATAN_TURNS[i]));
      end
      qd_r[i+1] <= qd_r[i];
    end
    unique case (qd_r[STAGES])
      QUAD_1: begin
        x_out_r <= -y_r[STAGES];
        y_out_r <= x_r[STAGES];
      end
      QUAD_2: begin
        x_out_r <= -x_r[STAGES];
        y_out_r <= -y_r[STAGES];
      end
      QUAD_3: begin
        x_out_r <= y_r[STAGES];
        y_out_r <= -x_r[STAGES];
      end
      default: begin
        x_out_r <= x_r[STAGES];
        y_out_r <= y_r[STAGES];
      end
    endcase
  end

  assign x_out = x_out_r;
  assign y_out = y_out_r;

endmodule

// ===== design/fqm_back.sv =====
// fqm_back: CORDIC for both components, exp(-2 t^2) series, scaling and saturation.
// Depends on fqm_pkg and fqm_cordic.
module fqm_back #(
  parameter int CORDIC_STAGES = fqm_pkg::CORDIC_STAGES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        item_valid,
  input  fqm_pkg::item_t              item,
  output logic                        out_valid,
  output logic signed [fqm_pkg::OUT_W-1:0] out_q,
  output logic signed [fqm_pkg::OUT_W-1:0] out_u,
  output logic                        out_sat
);
  import fqm_pkg::*;

  localparam int HL         = 3 * HORNER_TERMS;       // three stages per series term
  localparam int DAMP_LAT   = HL + EXP_STAGES;
  localparam int CORDIC_LAT = CORDIC_STAGES + 2;
  localparam int DLY        = DAMP_LAT - CORDIC_LAT;
  localparam int SW         = XW + 1;
  localparam int PW         = SW + 31;

  typedef struct packed {
    logic             sat;
    logic [OUT_W-1:0] val;
  } scaled_t;

  // floor(p/k) from the reciprocal estimate, which is low by at most one
  function automatic logic [31:0] horner_fix(logic [31:0] p, logic [31:0] q0, logic [3:0] k);
    logic [35:0] rem;
    rem = 36'(p) - 36'(q0) * 36'(k);
    return (rem >= 36'(k)) ? q0 + 32'd1 : q0;
  endfunction

  // round half away from zero, restore sign, clip
  function automatic scaled_t scale_out(logic [PW-1:0] prod, logic neg);
    logic [PW:0] rnd;
    logic [22:0] v;
    scaled_t     s;
    rnd = (PW + 1)'(prod) + ((PW + 1)'(1) << 43);
    v   = rnd[PW:44];
    if (!neg) begin
      s.sat = (v > 23'd131071);
      s.val = s.sat ? OUT_W'(18'h1FFFF) : v[OUT_W-1:0];
    end else begin
      s.sat = (v > 23'd131072);
      s.val = s.sat ? OUT_W'(18'h20000) : OUT_W'(23'(0) - v);
    end
    return s;
  endfunction

  logic signed [XW-1:0] x1, y1, x2, y2;

  fqm_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_one (
    .clk   (clk),
    .comp  (item.comp_one),
    .x_out (x1),
    .y_out (y1)
  );

  fqm_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_two (
    .clk   (clk),
    .comp  (item.comp_two),
    .x_out (x2),
    .y_out (y2)
  );

  // damping side-band carried alongside the series
  logic        cv_r [DAMP_LAT];
  logic [4:0]  cn_r [DAMP_LAT];
  logic [31:0] cf_r [DAMP_LAT];
  logic        cz_r [DAMP_LAT];

  logic [31:0] hp_r  [HORNER_TERMS];
  logic [31:0] hpp_r [HORNER_TERMS];
  logic [31:0] hq_r  [HORNER_TERMS];
  logic [32:0] hr_r  [HORNER_TERMS];
  logic [32:0] er_r  [EXP_STAGES];

  logic signed [SW-1:0] dq_r [DLY];
  logic signed [SW-1:0] du_r [DLY];

  logic          pv_r, mv_r, ov_r;
  logic          pneg_q_r, pneg_u_r, mneg_q_r, mneg_u_r;
  logic [SW-1:0] pmag_q_r, pmag_u_r;
  logic [30:0]   d30_r;
  logic [PW-1:0] mq_r, mu_r;
  scaled_t       sq, su;
  logic signed [OUT_W-1:0] out_q_r, out_u_r;
  logic          out_sat_r;

  // transaction valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < DAMP_LAT; s++) cv_r[s] <= 1'b0;
      pv_r <= 1'b0;
      mv_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      cv_r[0] <= item_valid;
      for (int s = 1; s < DAMP_LAT; s++) cv_r[s] <= cv_r[s-1];
      pv_r <= cv_r[DAMP_LAT-1];
      mv_r <= pv_r;
      ov_r <= mv_r;
    end
  end

  // exp(-f) by Horner, three stages a term: multiply, reciprocal, correct
  always_ff @(posedge clk) begin
    cn_r[0] <= item.exp_int;
    cf_r[0] <= item.exp_frac;
    cz_r[0] <= item.damp_zero;
    for (int s = 1; s < DAMP_LAT; s++) begin
      cn_r[s] <= cn_r[s-1];
      cf_r[s] <= cf_r[s-1];
      cz_r[s] <= cz_r[s-1];
    end
    hp_r[0] <= item.exp_frac;  // f times one
    for (int g = 1; g < HORNER_TERMS; g++) begin
      hp_r[g] <= 32'((65'(cf_r[3*g-1]) * 65'(hr_r[g-1])) >> 32);
    end
    for (int g = 0; g < HORNER_TERMS; g++) begin
      hq_r[g]  <= 32'((69'(hp_r[g]) * 69'(HORNER_RECIP[g])) >> 36);
      hpp_r[g] <= hp_r[g];
      hr_r[g]  <= ONE_Q32 - 33'(horner_fix(hpp_r[g], hq_r[g], 4'(HORNER_TERMS - g)));
    end
  end

  // times e^-1 for each unit of the integer part
  always_ff @(posedge clk) begin
    if (5'd0 < cn_r[HL-1]) begin
      er_r[0] <= 33'((64'(hr_r[HORNER_TERMS-1]) * 64'(E_INV)) >> 32);
    end else begin
      er_r[0] <= hr_r[HORNER_TERMS-1];
    end
    for (int j = 1; j < EXP_STAGES; j++) begin
      if (5'(j) < cn_r[HL-1+j]) begin
        er_r[j] <= 33'((64'(er_r[j-1]) * 64'(E_INV)) >> 32);
      end else begin
        er_r[j] <= er_r[j-1];
      end
    end
  end

  // component sums, delayed to meet the damping factor
  always_ff @(posedge clk) begin
    dq_r[0] <= SW'(x1) + SW'(x2);
    du_r[0] <= SW'(y1) + SW'(y2);
    for (int d = 1; d < DLY; d++) begin
      dq_r[d] <= dq_r[d-1];
      du_r[d] <= du_r[d-1];
    end
  end

  // magnitude and factor, product, round and clip
  always_ff @(posedge clk) begin
    pneg_q_r <= dq_r[DLY-1][SW-1];
    pneg_u_r <= du_r[DLY-1][SW-1];
    pmag_q_r <= dq_r[DLY-1][SW-1] ? SW'(-dq_r[DLY-1]) : SW'(dq_r[DLY-1]);
    pmag_u_r <= du_r[DLY-1][SW-1] ? SW'(-du_r[DLY-1]) : SW'(du_r[DLY-1]);
    d30_r    <= cz_r[DAMP_LAT-1] ? 31'd0 : er_r[EXP_STAGES-1][32:2];
    mq_r     <= PW'(pmag_q_r) * PW'(d30_r);
    mu_r     <= PW'(pmag_u_r) * PW'(d30_r);
    mneg_q_r <= pneg_q_r;
    mneg_u_r <= pneg_u_r;
    out_q_r   <= sq.val;
    out_u_r   <= su.val;
    out_sat_r <= sq.sat | su.sat;
  end

  assign sq = scale_out(mq_r, mneg_q_r);
  assign su = scale_out(mu_r, mneg_u_r);

  assign out_valid = ov_r;
  assign out_q     = out_q_r;
  assign out_u     = out_u_r;
  assign out_sat   = out_sat_r;

endmodule

// ===== design/faraday_two_component_qu_model_unit.sv =====
// Two-component Faraday rotation Q/U model: register file and front/queue/back assembly.
// Depends on fqm_pkg, fqm_front, fqm_queue, fqm_back.
//
// One squared-wavelength sample is taken per clock (start high while busy is low) and
// every sample yields exactly one result, shown on the out_ ports for one cycle with
// out_valid high; the receiver cannot hold results off and none is dropped. Latency is
// set by the damping factor: a 12-term exp series at three stages per term followed by
// 31 multiply-by-e^-1 stages. The CORDIC rotators (CORDIC_STAGES deep) run alongside
// and are delayed to match. busy only rises if the front-to-back queue fills, which
// does not happen in operation. The user must write the registers through cfg_we/
// cfg_index/cfg_data only while no sample is in flight; the block does not check.
module faraday_two_component_qu_model_unit #(
  parameter int CORDIC_STAGES = fqm_pkg::CORDIC_STAGES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [fqm_pkg::LAM_W-1:0]          in_wavelength_sq,
  output logic                               out_valid,
  output logic signed [fqm_pkg::OUT_W-1:0]   out_stokes_q,
  output logic signed [fqm_pkg::OUT_W-1:0]   out_stokes_u,
  output logic                               out_saturated,
  input  logic                               cfg_we,
  input  logic [fqm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fqm_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import fqm_pkg::*;

  cfg_t  cfg_r;
  logic  accept;
  logic  front_valid;
  item_t front_item;
  logic  q_full;
  logic  head_valid;
  item_t head_item;

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.amp_one         <= 17'd65536;
      cfg_r.amp_two         <= '0;
      cfg_r.angle_one       <= '0;
      cfg_r.angle_two       <= '0;
      cfg_r.rot_measure_one <= '0;
      cfg_r.rot_measure_two <= '0;
      cfg_r.dispersion      <= 24'd65536;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_AMP_ONE:    cfg_r.amp_one         <= cfg_data[16:0];
        REG_AMP_TWO:    cfg_r.amp_two         <= cfg_data[16:0];
        REG_ANGLE_ONE:  cfg_r.angle_one       <= cfg_data[15:0];
        REG_ANGLE_TWO:  cfg_r.angle_two       <= cfg_data[15:0];
        REG_RM_ONE:     cfg_r.rot_measure_one <= cfg_data[28:0];
        REG_RM_TWO:     cfg_r.rot_measure_two <= cfg_data[28:0];
        REG_DISPERSION: cfg_r.dispersion      <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  assign busy   = q_full;
  assign accept = start & ~q_full;

  fqm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .lam        (in_wavelength_sq),
    .cfg        (cfg_r),
    .item_valid (front_valid),
    .item       (front_item)
  );

  fqm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (front_valid),
    .push_item (front_item),
    .full      (q_full),
    .pop_valid (head_valid),
    .pop_item  (head_item)
  );

  fqm_back #(.CORDIC_STAGES(CORDIC_STAGES)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (head_valid),
    .item       (head_item),
    .out_valid  (out_valid),
    .out_q      (out_stokes_q),
    .out_u      (out_stokes_u),
    .out_sat    (out_saturated)
  );

endmodule
